// ----- rtl/core/mtt_pkg.sv -----
package mtt_pkg;

  // Result items one input byte can cause
  localparam int MaxResults = 4;
  // Default depth of the queue between front and back
  localparam int QueueDepth = 2;

  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrPeriod = 8'h2E;
  localparam logic [7:0] ChrComma  = 8'h2C;
  localparam logic [7:0] ChrDash   = 8'h2D;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrUpperZ = 8'h5A;
  localparam logic [7:0] CaseShift = 8'h20;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } item_t;

  // All result items of one input byte
  typedef struct packed {
    logic [2:0]                 cnt;
    item_t [MaxResults-1:0]     items;
  } bundle_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= ChrZero) && (b <= ChrNine);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    is_punct = ((b >= 8'h21) && (b <= 8'h26)) || ((b >= 8'h28) && (b <= 8'h2B)) ||
               (b == 8'h2F) || ((b >= 8'h3A) && (b <= 8'h40)) ||
               ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h7E));
  endfunction

endpackage

// ----- rtl/core/mtt_front.sv -----
module mtt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_end_of_line,
  input  mtt_pkg::q_stat_t q_stat,
  output logic             push,
  output mtt_pkg::bundle_t push_data
);
  import mtt_pkg::*;

  logic [7:0] held_mark_r, held_mark_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       prev_digit_r, prev_digit_nxt;
  logic       space_owed_r, space_owed_nxt;
  logic       line_started_r, line_started_nxt;
  logic       mark_open_r, mark_open_nxt;

  logic       accept;
  logic [7:0] c;
  logic       dig;
  logic       split;
  logic       open;
  logic [2:0] n;
  bundle_t    bnd;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Lowercase and classify the request byte
  assign c   = ((in_byte >= ChrUpperA) && (in_byte <= ChrUpperZ)) ? in_byte + CaseShift
                                                                   : in_byte;
  assign dig = is_digit(c);

  always_comb begin
    split = 1'b0;
    open  = 1'b0;
    if (is_punct(c)) begin
      split = 1'b1;
    end else if ((c == ChrPeriod) || (c == ChrComma)) begin
      open  = prev_digit_r;
      split = !prev_digit_r;
    end else if (c == ChrDash) begin
      split = prev_digit_r;
    end
  end

  // Build the result bundle and the next line state
  always_comb begin
    held_mark_nxt    = held_mark_r;
    held_valid_nxt   = held_valid_r;
    prev_digit_nxt   = prev_digit_r;
    space_owed_nxt   = space_owed_r;
    line_started_nxt = line_started_r;
    mark_open_nxt    = 1'b0;
    n                = 3'd0;
    bnd              = '0;

    // Settle a pending period or comma with this byte as lookahead
    if (mark_open_r && !dig) begin
      bnd.items[n[1:0]] = '{data: ChrSpace, valid: 1'b1, last: 1'b0};
      n                 = n + 3'd1;
      space_owed_nxt    = 1'b1;
    end

    if (c == ChrSpace) begin
      space_owed_nxt = 1'b1;
      prev_digit_nxt = 1'b0;
    end else begin
      if (held_valid_r) begin
        bnd.items[n[1:0]] = '{data: held_mark_r, valid: 1'b1, last: 1'b0};
        n                 = n + 3'd1;
        if (space_owed_nxt || split) begin
          bnd.items[n[1:0]] = '{data: ChrSpace, valid: 1'b1, last: 1'b0};
          n                 = n + 3'd1;
        end
      end
      held_mark_nxt    = c;
      held_valid_nxt   = 1'b1;
      line_started_nxt = 1'b1;
      space_owed_nxt   = split;
      mark_open_nxt    = open;
      prev_digit_nxt   = dig;
    end

    // Close the line: trailing split mark, then the last byte or end marker
    if (in_end_of_line) begin
      if (mark_open_nxt && !n[2]) begin
        bnd.items[n[1:0]] = '{data: ChrSpace, valid: 1'b1, last: 1'b0};
        n                 = n + 3'd1;
      end
      if (!n[2]) begin
        if (held_valid_nxt && line_started_nxt) begin
          bnd.items[n[1:0]] = '{data: held_mark_nxt, valid: 1'b1, last: 1'b1};
        end else begin
          bnd.items[n[1:0]] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
        end
        n = n + 3'd1;
      end
      held_mark_nxt    = '0;
      held_valid_nxt   = 1'b0;
      prev_digit_nxt   = 1'b0;
      space_owed_nxt   = 1'b0;
      line_started_nxt = 1'b0;
      mark_open_nxt    = 1'b0;
    end
    bnd.cnt = n;
  end

  assign push      = accept && (n != 3'd0);
  assign push_data = bnd;

  // Advance line state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mark_r    <= '0;
      held_valid_r   <= 1'b0;
      prev_digit_r   <= 1'b0;
      space_owed_r   <= 1'b0;
      line_started_r <= 1'b0;
      mark_open_r    <= 1'b0;
    end else if (accept) begin
      held_mark_r    <= held_mark_nxt;
      held_valid_r   <= held_valid_nxt;
      prev_digit_r   <= prev_digit_nxt;
      space_owed_r   <= space_owed_nxt;
      line_started_r <= line_started_nxt;
      mark_open_r    <= mark_open_nxt;
    end
  end

endmodule

// ----- rtl/core/mtt_queue.sv -----
module mtt_queue #(
  parameter int Depth = mtt_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mtt_pkg::bundle_t push_data,
  input  logic             pop,
  output mtt_pkg::bundle_t head,
  output mtt_pkg::q_stat_t q_stat
);
  import mtt_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t           slots_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count_r == CntW'(Depth));
  assign q_stat.empty = (count_r == '0);
  assign head         = slots_r[rd_ptr_r];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Hold queued bundles
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/mtt_back.sv -----
module mtt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mtt_pkg::bundle_t head,
  input  mtt_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last_of_line
);
  import mtt_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  item_t      out_item_r;
  logic       load;
  logic       emit;
  logic       at_end;

  // Refill the output register when it is empty or being taken
  assign load   = !out_valid_r || out_ready;
  assign emit   = load && !q_stat.empty;
  assign at_end = ({1'b0, idx_r} + 3'd1) == head.cnt;
  assign pop    = emit && at_end;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= head.items[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_item_r.data;
  assign out_byte_valid   = out_item_r.valid;
  assign out_last_of_line = out_item_r.last;

endmodule

// ----- rtl/core/mt_eval_text_tokenizer.sv -----
// Streaming line tokenizer in the mteval style: a line enters one byte per
// request and leaves as tokenized bytes, lowercased, punctuation split into
// tokens, space runs collapsed, with last_of_line on the final byte and a
// single end marker (byte_valid low) for a line that holds no token. The
// front classifies each byte combinationally and can take a new byte every
// cycle while the queue has room; it writes the zero to four result bytes
// that byte causes into a QUEUE_DEPTH-entry queue. The back drains that
// queue at one result byte per cycle, while out_ready is high, through a
// registered output, so the single output port sets the sustained rate.
// With the queue empty, the first result of a request passes through a
// queue slot and then the output register before it shows on the output.
module mt_eval_text_tokenizer #(
  parameter int QUEUE_DEPTH = mtt_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_line
);
  import mtt_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;

  mtt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_line (in_end_of_line),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  mtt_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  mtt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_of_line (out_last_of_line)
  );

endmodule

// ----- rtl/core/mtt_checker.sv -----
module mtt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_end_of_line,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_last_of_line
);

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_last_of_line))
    else $error("result changed while stalled");

  // End marker closes the line and carries a zero byte
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last_of_line && (out_byte == 8'h00))
    else $error("end marker malformed");

  // Uppercase never leaves the block
  a_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_byte >= 8'h41) && (out_byte <= 8'h5A)))
    else $error("uppercase byte in result");

  // A line never ends on a space
  a_no_trail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_line |-> (out_byte != 8'h20))
    else $error("trailing space in result line");

endmodule

bind mt_eval_text_tokenizer mtt_checker u_mtt_checker (.*);
